// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the next-greater-element block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== hdl/nges_pkg.sv =====
// Package with the shared constants, types and state codes of the next-greater-element block.
package nges_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // Input queue geometry.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int VALUE_W = 32;

   // One queued input item.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      end_of_sequence;
   } item_type;

   // One result item.
   typedef struct packed {
      logic signed [VALUE_W-1:0] element;
      logic signed [VALUE_W-1:0] greater_value;
      logic                      has_greater;
      logic                      last_of_run;
      logic                      overflow;
   } result_type;

   // Engine status seen by the top level.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             flushing;
   } status_type;

   // Engine sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_FLUSH,
      ST_REFILL
   } engine_state_type;

endpackage

// ===== hdl/next_greater_element_stack.sv =====
// Top level of the next-greater-element block: input queue, stack engine and checks.
// Each input transaction carries one signed value; the block reports, for every earlier value
// still waiting, the first later value strictly larger than it, and flushes the waiting values
// without a partner when tlast marks the end of a sequence. Up to 32 values wait on the stack;
// a value arriving at a full stack that pops nothing is reported back with the overflow flag.
// Flow: an item leaves the two-entry input queue in the idle state and is compared against
// the top of stack; every entry it pops or flushes is emitted as a result, after which the
// second stack entry is refilled from the stack memory's registered read port, except after
// the last flushed entry. A dropped value is reported from the compare state. Results leave
// through an output register, so the next item is taken while an earlier result still waits
// on rsp_tready.
`include "assert_macros.svh"

module next_greater_element_stack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // end of sequence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] element, [63:32] greater_value
   output logic        rsp_tlast,   // last result of the input transaction
   output logic [1:0]  rsp_tuser    // [0] has_greater, [1] overflow
);

   logic                   q_valid;
   logic                   q_pop;
   nges_pkg::item_type     q_item;
   nges_pkg::status_type   status;

   // Front: accept and queue input transactions.
   nges_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back: stack engine and result register.
   nges_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .status     (status)
   );

   // The stack never holds more entries than it has room for.
   `ASSERT_ALWAYS(a_count_bound, status.count <= nges_pkg::CNT_W'(nges_pkg::STACK_DEPTH), "stack count above depth")

   // A flush only runs while entries remain.
   `ASSERT_IMPLIES(a_flush_nonempty, status.flushing, status.count != '0, "flush with empty stack")

   // A dropped value never claims a greater partner.
   `ASSERT_IMPLIES(a_drop_no_pair, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0], "overflow result with pair")

   // A reported pair is strictly increasing.
   `ASSERT_IMPLIES(a_pair_order, rsp_tvalid && rsp_tuser[0], $signed(rsp_tdata[31:0]) < $signed(rsp_tdata[63:32]), "pair not increasing")

endmodule

// ===== hdl/nges_queue.sv =====
// Front part: accepts input transactions and holds them in a short queue for the engine.
module nges_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,
   input  logic                 req_tlast,
   output logic                 q_valid,
   output nges_pkg::item_type   q_item,
   input  logic                 q_pop
);

   nges_pkg::item_type                  slot_ff [nges_pkg::QUEUE_DEPTH];
   logic [nges_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [nges_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [nges_pkg::QCNT_W-1:0]         fill_ff, fill_in;
   logic                                push;
   logic                                pop;

   // Handshake on both sides of the queue.
   assign req_tready = (fill_ff != nges_pkg::QCNT_W'(nges_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = slot_ff[rd_ptr_ff];

   // Pointer and fill arithmetic, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == nges_pkg::QPTR_W'(nges_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == nges_pkg::QPTR_W'(nges_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Item storage; the end-of-sequence mark is taken from tlast.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].value           <= $signed(req_tdata);
         slot_ff[wr_ptr_ff].end_of_sequence <= req_tlast;
      end
   end

endmodule

// ===== hdl/nges_engine.sv =====
// Back part: runs the monotonic stack for one item at a time and drives the result register.
module nges_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  nges_pkg::item_type     q_item,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   output logic                   rsp_tlast,
   output logic [1:0]             rsp_tuser,
   output nges_pkg::status_type   status
);

   localparam int CW = nges_pkg::CNT_W;
   localparam int IW = nges_pkg::IDX_W;

   nges_pkg::engine_state_type          state_ff, state_in;
   nges_pkg::item_type                  cur_ff;
   logic                                drop_ff;
   logic                                ret_flush_ff;
   logic signed [nges_pkg::VALUE_W-1:0] top_ff;
   logic signed [nges_pkg::VALUE_W-1:0] below_ff;
   logic signed [nges_pkg::VALUE_W-1:0] rd_ff;
   logic [CW-1:0]                       count_ff;
   logic signed [nges_pkg::VALUE_W-1:0] stack_mem [nges_pkg::STACK_DEPTH];
   logic                                rsp_valid_ff;
   nges_pkg::result_type                rsp_ff;

   logic                                out_free;
   logic                                top_lt;
   logic                                below_ge;
   logic                                full;
   logic                                last_pop;
   logic                                emit;
   logic                                do_pop;
   logic                                do_push;
   logic                                do_drop;
   nges_pkg::result_type                res;
   logic [CW-1:0]                       rd_count;

   // Shared conditions of the sequencer.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign top_lt   = (count_ff != '0) && (top_ff < cur_ff.value);
   assign below_ge = !(below_ff < cur_ff.value);
   assign full     = (count_ff == CW'(nges_pkg::STACK_DEPTH));
   assign last_pop = !cur_ff.end_of_sequence && ((count_ff == CW'(1)) || below_ge);
   assign rd_count = count_ff - CW'(3);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nges_pkg::ST_IDLE: begin
            if (q_valid) state_in = nges_pkg::ST_CMP;
         end
         nges_pkg::ST_CMP: begin
            if (top_lt) begin
               if (out_free) state_in = nges_pkg::ST_REFILL;
            end else if (!full || out_free) begin
               state_in = cur_ff.end_of_sequence ? nges_pkg::ST_FLUSH : nges_pkg::ST_IDLE;
            end
         end
         nges_pkg::ST_FLUSH: begin
            if (count_ff == '0) begin
               state_in = nges_pkg::ST_IDLE;
            end else if (out_free) begin
               state_in = (count_ff == CW'(1)) ? nges_pkg::ST_IDLE : nges_pkg::ST_REFILL;
            end
         end
         nges_pkg::ST_REFILL: begin
            state_in = ret_flush_ff ? nges_pkg::ST_FLUSH : nges_pkg::ST_CMP;
         end
         default: state_in = nges_pkg::ST_IDLE;
      endcase
   end

   // Actions and result fields of the current state.
   always_comb begin
      q_pop   = 1'b0;
      emit    = 1'b0;
      do_pop  = 1'b0;
      do_push = 1'b0;
      do_drop = 1'b0;
      res     = '0;
      unique case (state_ff)
         nges_pkg::ST_IDLE: begin
            q_pop = q_valid;
         end
         nges_pkg::ST_CMP: begin
            if (top_lt) begin
               // Waiting value meets its next greater element.
               emit              = out_free;
               do_pop            = out_free;
               res.element       = top_ff;
               res.greater_value = cur_ff.value;
               res.has_greater   = 1'b1;
               res.last_of_run   = last_pop;
            end else if (!full) begin
               do_push = 1'b1;
            end else begin
               // Stack full with no room made: the value is dropped.
               emit            = out_free;
               do_drop         = out_free;
               res.element     = cur_ff.value;
               res.last_of_run = !cur_ff.end_of_sequence;
               res.overflow    = 1'b1;
            end
         end
         nges_pkg::ST_FLUSH: begin
            emit            = out_free && (count_ff != '0);
            do_pop          = emit;
            res.element     = top_ff;
            res.last_of_run = (count_ff == CW'(1));
            res.overflow    = drop_ff;
         end
         nges_pkg::ST_REFILL: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nges_pkg::ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         ret_flush_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_pop) begin
            count_ff     <= count_ff - CW'(1);
            ret_flush_ff <= (state_ff == nges_pkg::ST_FLUSH);
         end else if (do_push) begin
            count_ff <= count_ff + CW'(1);
         end
         if (q_pop) begin
            drop_ff <= 1'b0;
         end else if (do_drop) begin
            drop_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Top and second entry are held in registers; a pop refills the second from memory.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (do_push) begin
         top_ff   <= cur_ff.value;
         below_ff <= top_ff;
      end else if (do_pop) begin
         top_ff <= below_ff;
      end else if (state_ff == nges_pkg::ST_REFILL) begin
         below_ff <= rd_ff;
      end
      if (emit) begin
         rsp_ff <= res;
      end
   end

   // Stack memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[count_ff[IW-1:0]] <= cur_ff.value;
      end
      if (do_pop && (count_ff >= CW'(3))) begin
         rd_ff <= stack_mem[rd_count[IW-1:0]];
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {rsp_ff.greater_value, rsp_ff.element};
   assign rsp_tlast       = rsp_ff.last_of_run;
   assign rsp_tuser       = {rsp_ff.overflow, rsp_ff.has_greater};
   assign status.count    = count_ff;
   assign status.flushing = (state_ff == nges_pkg::ST_FLUSH);

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the next-greater-element stack block.
`timescale 1ns / 100ps

module testbench;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int RANDOM_ITEMS = 320;
   localparam int DRAIN_CYCLES = 50;

   // One value waiting to be sent, with its end-of-sequence mark.
   typedef struct {
      logic signed [31:0] value;
      logic               end_of_sequence;
   } seq_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tlast = 1'b0; // end of sequence
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [31:0] element, [63:32] greater_value
   logic        rsp_tlast;        // last result of the input transaction
   logic [1:0]  rsp_tuser;        // [0] has_greater, [1] overflow

   // Values queued for the driver and pairs expected back from the block.
   seq_item_type          values_to_send[$];
   nges_pkg::result_type  predicted_pairs[$];

   // Shadow copy of the waiting stack.
   logic signed [31:0] waiting_vals [nges_pkg::STACK_DEPTH];
   int                 waiting_count = 0;

   int  values_queued = 0;
   int  values_accepted = 0;
   int  errors = 0;
   int  pairs_seen = 0;
   int  flushed_seen = 0;
   int  dropped_seen = 0;
   int  longest_run = 0;
   int  run_length = 0;
   bit  req_fired = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  send_quiet = 1'b0;
   bit  recv_quiet = 1'b0;

   next_greater_element_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Works out the pairs one accepted value causes and updates the shadow stack.
   function automatic void predict_next_greater(logic signed [31:0] v, logic eos);
      nges_pkg::result_type run[$];
      nges_pkg::result_type r;
      bit                   dropped;
      dropped = 1'b0;
      // Pop every waiting value strictly smaller than the new one.
      while (waiting_count > 0 && waiting_vals[waiting_count-1] < v) begin
         waiting_count--;
         r = '{waiting_vals[waiting_count], v, 1'b1, 1'b0, 1'b0};
         run.push_back(r);
      end
      // Push, or drop when the stack is full.
      if (waiting_count < nges_pkg::STACK_DEPTH) begin
         waiting_vals[waiting_count] = v;
         waiting_count++;
      end else begin
         dropped = 1'b1;
         r = '{v, 32'sd0, 1'b0, 1'b0, 1'b0};
         run.push_back(r);
      end
      // End of sequence flushes the stack from the top.
      if (eos) begin
         while (waiting_count > 0) begin
            waiting_count--;
            r = '{waiting_vals[waiting_count], 32'sd0, 1'b0, 1'b0, 1'b0};
            run.push_back(r);
         end
      end
      foreach (run[i]) begin
         r = run[i];
         r.overflow = dropped;
         r.last_of_run = (i == run.size() - 1);
         predicted_pairs.push_back(r);
      end
   endfunction

   task automatic queue_value(logic signed [31:0] v, logic eos);
      seq_item_type it;
      it.value = v;
      it.end_of_sequence = eos;
      values_to_send.push_back(it);
      values_queued++;
   endtask

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, expected, actual);
         errors++;
      end
   endtask

   // Waits until every queued value is taken and every predicted pair has arrived.
   task automatic wait_drained();
      do @(negedge clock);
      while (values_accepted != values_queued || predicted_pairs.size() != 0);
   endtask

   // Input driver: holds a transaction until accepted, then inserts a random gap.
   always @(negedge clock) begin : drive_values
      seq_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (values_to_send.size() > 0) begin
            it = values_to_send.pop_front();
            req_tdata  <= it.value;
            req_tlast  <= it.end_of_sequence;
            req_tvalid <= 1'b1;
            send_gap = send_quiet ? 0 : draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 49) == 0) recv_quiet = !recv_quiet;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!recv_quiet && $urandom_range(0, 3) == 0) stall_left = draw_gap();
         end
      end
   end

   // Monitor: checks each result transaction, then predicts from each input transaction.
   always @(posedge clock) begin : watch_ports
      nges_pkg::result_type expected;
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            run_length++;
            // A drop is always the first result of its input; later overflow results are flushes.
            if (rsp_tuser[0]) pairs_seen++;
            else if (rsp_tuser[1] && run_length == 1) dropped_seen++;
            else flushed_seen++;
            if (rsp_tlast) begin
               if (run_length > longest_run) longest_run = run_length;
               run_length = 0;
            end
            if (predicted_pairs.size() == 0) begin
               $display("%0t: unexpected result, expected none, got data %h last %b user %b",
                        $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end else begin
               expected = predicted_pairs.pop_front();
               check_field("element", expected.element, rsp_tdata[31:0]);
               check_field("greater_value", expected.greater_value, rsp_tdata[63:32]);
               check_field("has_greater", 32'(expected.has_greater), 32'(rsp_tuser[0]));
               check_field("last_of_run", 32'(expected.last_of_run), 32'(rsp_tlast));
               check_field("overflow", 32'(expected.overflow), 32'(rsp_tuser[1]));
            end
         end
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            values_accepted++;
            predict_next_greater(req_tdata, req_tlast);
         end
      end
   end

   // Stimulus: directed sequences, a full drain, then random sequences.
   initial begin : stimulus
      int kind;
      int len;
      int seq_index;
      int random_sent;
      logic signed [31:0] v;
      logic signed [31:0] center;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Equal values stay waiting, the maximum pops everything below it.
      queue_value(32'sd0, 1'b0);
      queue_value(-32'sd1, 1'b0);
      queue_value(-32'sd1, 1'b0);
      queue_value(32'sd1, 1'b0);
      queue_value(32'sd1, 1'b0);
      queue_value(VAL_MIN, 1'b0);
      queue_value(VAL_MAX, 1'b1);
      // End of sequence on an empty stack.
      queue_value(32'sd5, 1'b1);
      // Equal maxima produce no results until the flush.
      queue_value(VAL_MAX, 1'b0);
      queue_value(VAL_MAX, 1'b0);
      queue_value(VAL_MIN, 1'b1);
      queue_value(VAL_MIN, 1'b0);
      queue_value(VAL_MIN, 1'b0);
      queue_value(VAL_MAX, 1'b0);
      queue_value(-32'sd1, 1'b1);

      // Sender holds off until the block has returned everything.
      wait_drained();

      random_sent = 0;
      seq_index = 0;
      while (random_sent < RANDOM_ITEMS) begin
         kind = (seq_index == 0) ? 0 : $urandom_range(0, 9);
         if (kind <= 1) begin
            // Non-increasing run that fills the stack; values past the depth are dropped.
            len = nges_pkg::STACK_DEPTH + $urandom_range(0, 3);
            v = $urandom_range(0, 32'h7fff_ffff);
            for (int i = 0; i < len; i++) begin
               queue_value(v, i == len - 1);
               v = v - $urandom_range(0, 1000);
            end
         end else if (kind <= 5) begin
            // Full-range random values.
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) queue_value($urandom(), i == len - 1);
         end else if (kind <= 8) begin
            // Narrow range around zero or an extreme, so equal values are common.
            case ($urandom_range(0, 2))
               0: center = VAL_MIN + 2;
               1: center = 32'sd0;
               default: center = VAL_MAX - 2;
            endcase
            len = $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
               queue_value(center + $signed($urandom_range(0, 4)) - 2, i == len - 1);
         end else begin
            // Broken sequence: end marks at random, possibly none.
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) queue_value($urandom(), $urandom_range(0, 2) == 0);
         end
         random_sent += len;
         seq_index++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d values in %0d random sequences plus a directed set.",
               values_accepted, seq_index);
      $display("Checked %0d popped pairs, %0d flushed entries, %0d drops; longest run %0d.",
               pairs_seen, flushed_seen, dropped_seen, longest_run);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin : watchdog
      #100_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
